[src/ccm_pkg.sv]
`default_nettype none

package ccm_pkg;

  typedef struct packed {
    logic        has_contact;
    logic [31:0] feature_key;
    logic [31:0] normal_impulse_in;
    logic [31:0] tangent_impulse_in;
    logic [31:0] binormal_impulse_in;
    logic        last_of_frame;
  } in_word_t;

  typedef struct packed {
    logic        matched;
    logic        overflow;
    logic [31:0] normal_impulse;
    logic [31:0] tangent_impulse;
    logic [31:0] binormal_impulse;
    logic        frame_done;
  } out_word_t;

  typedef struct packed {
    logic [31:0] normal;
    logic [31:0] tangent;
    logic [31:0] binormal;
  } imp_t;

  // One stored contact: its key and the impulses it left behind.
  typedef struct packed {
    logic [31:0] key;
    imp_t        imp;
  } entry_t;

  localparam logic [31:0] ZERO_IMPULSE = 32'h0000_0000;

  localparam logic WARM_START_RESET = 1'b1;

endpackage

`default_nettype wire

[src/ccm_in_if.sv]
`default_nettype none

interface ccm_in_if;
  import ccm_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

[src/ccm_out_if.sv]
`default_nettype none

interface ccm_out_if;
  import ccm_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

[src/ccm_store.sv]
`default_nettype none

module ccm_store #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output ccm_pkg::entry_t       rd_data,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  ccm_pkg::entry_t       wr_data
);
  import ccm_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/ccm_seq.sv]
`default_nettype none

module ccm_seq #(
  parameter int MAX_CONTACTS = 8,
  parameter int CNT_W        = 4,
  parameter int ADDR_W       = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  warm_start,
  input  logic                  in_valid,
  input  ccm_pkg::in_word_t     in_word,
  output logic                  in_ready,
  input  logic                  out_free,
  output logic                  res_valid,
  output ccm_pkg::out_word_t    res_word,
  output logic                  rd_en,
  output logic [ADDR_W-1:0]     rd_addr,
  input  ccm_pkg::entry_t       rd_data,
  output logic                  wr_en,
  output logic [ADDR_W-1:0]     wr_addr,
  output ccm_pkg::entry_t       wr_data
);
  import ccm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t          state;
  in_word_t        item;
  imp_t            merged;
  logic            hit;
  logic            pending;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] active_count;
  logic [CNT_W-1:0] building_count;
  logic             active_bank;

  logic             hit_now;
  logic             scan_end;
  logic             room;
  logic             finish_go;
  logic [CNT_W-1:0] building_count_next;
  logic [ADDR_W-1:0] active_base;
  logic [ADDR_W-1:0] building_base;

  always_comb begin
    active_base   = active_bank ? ADDR_W'(MAX_CONTACTS) : '0;
    building_base = active_bank ? '0 : ADDR_W'(MAX_CONTACTS);

    // Compare the word that the read of the previous cycle returned.
    hit_now  = pending && (rd_data.key == item.feature_key);
    scan_end = (scan_idx == active_count);

    rd_en   = (state == S_SCAN) && !hit_now && !scan_end;
    rd_addr = active_base + ADDR_W'(scan_idx);

    room      = (building_count != CNT_W'(MAX_CONTACTS));
    finish_go = (state == S_FINISH) && out_free;
    building_count_next = room ? building_count + CNT_W'(1) : building_count;

    wr_en           = finish_go && room;
    wr_addr         = building_base + ADDR_W'(building_count);
    wr_data.key     = item.feature_key;
    wr_data.imp     = merged;

    res_valid                 = finish_go;
    res_word.matched          = hit;
    res_word.overflow         = !room;
    res_word.normal_impulse   = merged.normal;
    res_word.tangent_impulse  = merged.tangent;
    res_word.binormal_impulse = merged.binormal;
    res_word.frame_done       = item.last_of_frame;

    in_ready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pending        <= 1'b0;
      active_count   <= '0;
      building_count <= '0;
      active_bank    <= 1'b0;
    end else begin
      pending <= rd_en;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_word;
            if (in_word.has_contact) begin
              state           <= S_SCAN;
              scan_idx        <= '0;
              hit             <= 1'b0;
              merged.normal   <= in_word.normal_impulse_in;
              merged.tangent  <= in_word.tangent_impulse_in;
              merged.binormal <= in_word.binormal_impulse_in;
            end else if (in_word.last_of_frame) begin
              // An empty word still closes the frame.
              active_bank    <= ~active_bank;
              active_count   <= building_count;
              building_count <= '0;
            end
          end
        end
        S_SCAN: begin
          if (hit_now) begin
            hit   <= 1'b1;
            state <= S_FINISH;
            if (warm_start) begin
              merged <= rd_data.imp;
            end else begin
              merged.normal   <= ZERO_IMPULSE;
              merged.tangent  <= ZERO_IMPULSE;
              merged.binormal <= ZERO_IMPULSE;
            end
          end else if (scan_end) begin
            state <= S_FINISH;
          end else begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
            if (item.last_of_frame) begin
              active_bank    <= ~active_bank;
              active_count   <= building_count_next;
              building_count <= '0;
            end else begin
              building_count <= building_count_next;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/contact_cache_merge.sv]
`default_nettype none

// Warm-start contact cache for one body pair.
// Channels: contacts (sink) takes one word per new contact of a frame;
// merged (source) returns one word per word that has has_contact set.
// A word with has_contact clear gives no result; with last_of_frame set it
// still closes the frame. cfg_we/cfg_wdata write the warm_start bit.
// Each contact's key is searched in the previous frame's bank, one stored
// entry per cycle through the single read port of the contact memory, and
// the merged contact is written into the other bank.
// The search stops at the first matching entry. The next word is accepted
// in the cycle after the result leaves the sequencer; no word is taken
// while a contact is searched or its result waits in the sequencer.
// Results wait in an output register; a stalled receiver holds that
// register, and the sequencer may still accept and search one more word
// before it waits for the register to drain.
// Reset clears both contact counts, selects bank 0 as active and sets
// warm_start to 1. The memory contents are not cleared.
module contact_cache_merge #(
  parameter int MAX_CONTACTS = 8
) (
  input  logic       clk,
  input  logic       rst,
  ccm_in_if.sink     contacts,
  ccm_out_if.source  merged,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import ccm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CONTACTS + 1);
  localparam int DEPTH  = 2 * MAX_CONTACTS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              warm_start;
  logic              out_valid;
  out_word_t         out_word;
  logic              out_free;
  logic              res_valid;
  out_word_t         res_word;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      warm_start <= WARM_START_RESET;
    end else if (cfg_we) begin
      warm_start <= cfg_wdata;
    end
  end

  assign out_free = !out_valid || merged.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_word <= res_word;
    end
  end

  assign merged.valid = out_valid;
  assign merged.word  = out_word;

  ccm_seq #(
    .MAX_CONTACTS (MAX_CONTACTS),
    .CNT_W        (CNT_W),
    .ADDR_W       (ADDR_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .warm_start (warm_start),
    .in_valid   (contacts.valid),
    .in_word    (contacts.word),
    .in_ready   (contacts.ready),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res_word   (res_word),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  ccm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

`default_nettype wire

[src/ccm_checker.sv]
`default_nettype none

module ccm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_has_contact,
  input logic                out_valid,
  input logic                out_ready,
  input ccm_pkg::out_word_t  out_word
);
  import ccm_pkg::*;

  // A stalled result word stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("merged word changed or dropped while stalled");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("merged valid after reset");

  // A contact word always takes a search, so the input closes behind it.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_has_contact |=> !in_ready)
    else $error("input still open right after a contact word");

  // A fresh result needs the search to have run: input was closed before.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a search cycle");

endmodule

bind contact_cache_merge ccm_checker u_ccm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (contacts.valid),
  .in_ready       (contacts.ready),
  .in_has_contact (contacts.word.has_contact),
  .out_valid      (merged.valid),
  .out_ready      (merged.ready),
  .out_word       (merged.word)
);

`default_nettype wire

[dv/contact_cache_merge_tb.sv]
`default_nettype none

module contact_cache_merge_tb;
  import ccm_pkg::*;

  localparam int MAX_CONTACTS = 8;
  localparam int TOTAL_CONTACTS = 1750;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NO_WRITE = -1;
  localparam logic [31:0] ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] Z = ZERO_IMPULSE;

  typedef struct {
    bit        has;
    bit [31:0] key;
    bit [31:0] pn;
    bit [31:0] pt;
    bit [31:0] pb;
    bit        last;
    int        ws;
    bit        typed;
    bit        m;
    bit        o;
    bit [31:0] en;
    bit [31:0] et;
    bit [31:0] eb;
  } plan_row_t;

  localparam int PLAN_LEN = 21;

  // Frame 1 fills an empty table, frame 2 hits it under both warm_start
  // settings and runs past capacity, then an empty frame clears the table,
  // and the last frames store one key twice so the first copy must win.
  plan_row_t plan [PLAN_LEN] = '{
    '{1, 32'h0, ONES, ONES, ONES, 0, NO_WRITE, 1, 0, 0, ONES, ONES, ONES},
    '{1, ONES, Z, Z, Z, 0, NO_WRITE, 1, 0, 0, Z, Z, Z},
    '{1, 32'h1234_5678, 32'h3F80_0000, 32'hBF80_0000, 32'h1, 1, NO_WRITE, 1, 0, 0,
      32'h3F80_0000, 32'hBF80_0000, 32'h1},
    '{1, ONES, 32'h1111_1111, 32'h1111_1111, 32'h1111_1111, 0, NO_WRITE, 1, 1, 0,
      Z, Z, Z},
    '{1, 32'h0, 32'h2222_2222, 32'h2222_2222, 32'h2222_2222, 0, 0, 1, 1, 0, Z, Z, Z},
    '{1, 32'h1234_5678, 32'h3333_3333, 32'h3333_3333, 32'h3333_3333, 0, 1, 1, 1, 0,
      32'h3F80_0000, 32'hBF80_0000, 32'h1},
    '{1, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 0, NO_WRITE, 0, 0, 0,
      Z, Z, Z},
    '{1, 32'h1, 32'h10, 32'h11, 32'h12, 0, NO_WRITE, 0, 0, 0, Z, Z, Z},
    '{1, 32'h2, 32'h20, 32'h21, 32'h22, 0, NO_WRITE, 0, 0, 0, Z, Z, Z},
    '{1, 32'h3, 32'h30, 32'h31, 32'h32, 0, NO_WRITE, 0, 0, 0, Z, Z, Z},
    '{1, 32'h4, 32'h40, 32'h41, 32'h42, 0, NO_WRITE, 0, 0, 0, Z, Z, Z},
    '{1, 32'h0, 32'h4444_4444, 32'h4444_4444, 32'h4444_4444, 0, NO_WRITE, 1, 1, 1,
      ONES, ONES, ONES},
    '{1, 32'h5, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 1, NO_WRITE, 1, 0, 1,
      32'h5555_5555, 32'h5555_5555, 32'h5555_5555},
    '{0, 32'hC3C3_C3C3, ONES, Z, ONES, 1, NO_WRITE, 0, 0, 0, Z, Z, Z},
    '{1, 32'h0, 32'h6666_6666, 32'h6666_6666, 32'h6666_6666, 0, NO_WRITE, 1, 0, 0,
      32'h6666_6666, 32'h6666_6666, 32'h6666_6666},
    '{0, ONES, ONES, ONES, ONES, 0, NO_WRITE, 0, 0, 0, Z, Z, Z},
    '{1, 32'h5, 32'h0101_0101, 32'h0101_0101, 32'h0101_0101, 0, NO_WRITE, 0, 0, 0,
      Z, Z, Z},
    '{1, 32'h5, 32'h0202_0202, 32'h0202_0202, 32'h0202_0202, 1, NO_WRITE, 0, 0, 0,
      Z, Z, Z},
    '{1, 32'h5, 32'h7777_7777, 32'h7777_7777, 32'h7777_7777, 0, NO_WRITE, 0, 0, 0,
      Z, Z, Z},
    '{1, 32'h5, 32'h9999_9999, 32'h9999_9999, 32'h9999_9999, 1, 0, 1, 1, 0, Z, Z, Z},
    '{1, 32'hDEAD_BEEF, 32'h8888_8888, 32'h8181_8181, 32'h1818_1818, 1, 1, 1, 0, 0,
      32'h8888_8888, 32'h8181_8181, 32'h1818_1818}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  ccm_in_if contacts_ch ();
  ccm_out_if merged_ch ();

  contact_cache_merge #(
    .MAX_CONTACTS(MAX_CONTACTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .contacts(contacts_ch),
    .merged(merged_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow of the cache: both banks, the counts and the register.
  entry_t      cache_mem [2 * MAX_CONTACTS];
  int          prev_count = 0;
  int          build_count = 0;
  bit          active_bank = 1'b0;
  bit          warm_start = WARM_START_RESET;

  out_word_t   pending_merges [$];
  int unsigned fail_count = 0;
  int unsigned contacts_sent = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_off_start = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit merge_contact(input in_word_t w, output out_word_t res);
    int   abase;
    int   bbase;
    bit   hit;
    imp_t imp;
    res = '0;
    abase = active_bank * MAX_CONTACTS;
    bbase = (active_bank ^ 1'b1) * MAX_CONTACTS;
    if (w.has_contact) begin
      hit = 1'b0;
      imp = {w.normal_impulse_in, w.tangent_impulse_in, w.binormal_impulse_in};
      for (int j = 0; j < prev_count; j++) begin
        if (!hit && cache_mem[abase + j].key == w.feature_key) begin
          hit = 1'b1;
          imp = warm_start ? cache_mem[abase + j].imp
                           : {ZERO_IMPULSE, ZERO_IMPULSE, ZERO_IMPULSE};
        end
      end
      if (build_count < MAX_CONTACTS) begin
        cache_mem[bbase + build_count] = {w.feature_key, imp};
        build_count++;
      end else begin
        res.overflow = 1'b1;
      end
      res.matched = hit;
      res.normal_impulse = imp.normal;
      res.tangent_impulse = imp.tangent;
      res.binormal_impulse = imp.binormal;
      res.frame_done = w.last_of_frame;
    end
    if (w.last_of_frame) begin
      active_bank = ~active_bank;
      prev_count = build_count;
      build_count = 0;
    end
    return w.has_contact;
  endfunction

  function automatic in_word_t random_word(bit has, bit last);
    in_word_t w;
    w.has_contact = has;
    w.feature_key = $urandom;
    w.normal_impulse_in = $urandom;
    w.tangent_impulse_in = $urandom;
    w.binormal_impulse_in = $urandom;
    w.last_of_frame = last;
    return w;
  endfunction

  // Most keys repeat one from the previous frame or the frame being built,
  // so that matches and duplicate keys are common.
  function automatic logic [31:0] choose_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55 && prev_count > 0)
      return cache_mem[active_bank * MAX_CONTACTS + $urandom_range(0, prev_count - 1)].key;
    if (r < 70 && build_count > 0)
      return cache_mem[(active_bank ^ 1'b1) * MAX_CONTACTS
                       + $urandom_range(0, build_count - 1)].key;
    return $urandom;
  endfunction

  task automatic push_word(input in_word_t w, input bit typed, input out_word_t fixed);
    out_word_t res;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 28) begin
      contacts_ch.valid <= 1'b0;
      @(negedge clk);
    end
    contacts_ch.valid <= 1'b1;
    contacts_ch.word <= w;
    do @(posedge clk); while (!contacts_ch.ready);
    if (merge_contact(w, res))
      pending_merges.push_back(typed ? fixed : res);
  endtask

  task automatic write_warm_start(input bit value);
    @(negedge clk);
    contacts_ch.valid <= 1'b0;
    while (pending_merges.size() != 0) @(negedge clk);
    // Empty words leave nothing to wait for, so give the search time to end.
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    warm_start = value;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && merged_ch.valid && merged_ch.ready) begin
      if (pending_merges.size() == 0) begin
        $error("merged word with no contact waiting for it");
        fail_count++;
      end else begin
        want = pending_merges.pop_front();
        check_field("matched", 32'(want.matched), 32'(merged_ch.word.matched));
        check_field("overflow", 32'(want.overflow), 32'(merged_ch.word.overflow));
        check_field("normal_impulse", want.normal_impulse, merged_ch.word.normal_impulse);
        check_field("tangent_impulse", want.tangent_impulse, merged_ch.word.tangent_impulse);
        check_field("binormal_impulse", want.binormal_impulse,
                    merged_ch.word.binormal_impulse);
        check_field("frame_done", 32'(want.frame_done), 32'(merged_ch.word.frame_done));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    merged_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_start) begin
        hold_off_start = 1'b0;
        merged_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      merged_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_word_t  w;
    out_word_t fixed;
    int        frame_len;
    int        pick;
    bit        split_close;
    bit        pressure_done;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    contacts_ch.valid = 1'b0;
    contacts_ch.word = '0;
    pressure_done = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].ws != NO_WRITE)
        write_warm_start(plan[i].ws[0]);
      w.has_contact = plan[i].has;
      w.feature_key = plan[i].key;
      w.normal_impulse_in = plan[i].pn;
      w.tangent_impulse_in = plan[i].pt;
      w.binormal_impulse_in = plan[i].pb;
      w.last_of_frame = plan[i].last;
      fixed.matched = plan[i].m;
      fixed.overflow = plan[i].o;
      fixed.normal_impulse = plan[i].en;
      fixed.tangent_impulse = plan[i].et;
      fixed.binormal_impulse = plan[i].eb;
      fixed.frame_done = plan[i].last;
      push_word(w, plan[i].typed, fixed);
      if (plan[i].has)
        contacts_sent++;
    end

    while (contacts_sent < TOTAL_CONTACTS) begin
      if ($urandom_range(0, 5) == 0)
        write_warm_start(1'($urandom_range(0, 1)));
      if (!pressure_done && contacts_sent >= 300) begin
        pressure_done = 1'b1;
        hold_off_start = 1'b1;
      end
      calm = contacts_sent >= 700 && contacts_sent < 1000;
      pick = $urandom_range(0, 99);
      frame_len = pick < 5 ? 0 : pick < 15 ? $urandom_range(9, 12) : $urandom_range(1, 8);
      split_close = frame_len == 0 || $urandom_range(0, 9) == 0;
      for (int k = 0; k < frame_len; k++) begin
        if ($urandom_range(0, 99) < 8)
          push_word(random_word(1'b0, 1'b0), 1'b0, '0);
        if ($urandom_range(0, 99) < 2)
          write_warm_start(1'($urandom_range(0, 1)));
        w = random_word(1'b1, k == frame_len - 1 && !split_close);
        w.feature_key = choose_key();
        push_word(w, 1'b0, '0);
        contacts_sent++;
      end
      if (split_close)
        push_word(random_word(1'b0, 1'b1), 1'b0, '0);
    end

    @(negedge clk);
    contacts_ch.valid <= 1'b0;
    calm = 1'b0;
    while (pending_merges.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
